[sv/mbp_pkg.sv]
// mbp_pkg: shared types and codes for the buffer pool frame table.
// Used by mru_buffer_pool_with_pins_unit. No dependencies.
package mbp_pkg;

   localparam int FRAMES_DEF   = 16;
   localparam int TAG_BITS_DEF = 32;
   localparam int CSR_DATA_W   = 13;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_PIN   = 2'd2,
      CMD_UNPIN = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_HIT          = 3'd0,
      ST_FILL_FREE    = 3'd1,
      ST_FILL_EVICT   = 3'd2,
      ST_ALL_PINNED   = 3'd3,
      ST_PIN_DONE     = 3'd4,
      ST_NOT_RESIDENT = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CSR_SECTORS_PER_BLOCK = 2'd0,
      CSR_SECTOR_BYTES      = 2'd1,
      CSR_FRAMES_IN_USE     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DIV,
      FSM_SCAN,
      FSM_DEC,
      FSM_UPD,
      FSM_OUT
   } fsm_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] sector_num;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  frame_slot;
      logic [19:0] byte_offset;
      logic [31:0] fill_block;
      logic [31:0] evicted_block;
      logic        writeback_needed;
      logic [31:0] total_accesses;
      logic [31:0] hit_count;
   } rsp_type;

endpackage

[sv/mru_buffer_pool_with_pins_unit.sv]
// Buffer pool frame table with MRU replacement, pin counts and dirty marks.
// Depends on mbp_pkg.
// Steps: a block divide, a scan over the frames, a decide step, an update pass
// (skipped on all-pinned / not-resident) and a load of the output, plus any wait
// on a stalled result. One item at a time: the next item is taken in the cycle
// after the result loads. Synchronous active-high reset empties the pool (valid
// flops), restores register defaults and clears counters; frame memory is not swept.
module mru_buffer_pool_with_pins_unit #(
   parameter int FRAMES   = mbp_pkg::FRAMES_DEF,
   parameter int TAG_BITS = mbp_pkg::TAG_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mbp_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mbp_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [mbp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;   // slot index / rank
   localparam int CW = $clog2(FRAMES + 1);                  // walk counter, occupancy

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic                dirty;
      logic [7:0]          pins;
      logic [IW-1:0]       rank;
   } entry_type;

   // frame memory: one entry per frame, registered read
   entry_type mem [FRAMES];
   entry_type rd_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // config registers
   logic [8:0]  spb_ff;
   logic [12:0] sbytes_ff;
   logic [4:0]  fiu_ff;

   // control
   mbp_pkg::fsm_type state_ff, state_in;
   logic [FRAMES-1:0] valid_ff;
   logic [CW-1:0]     cnt_ff;
   logic [5:0]        dcnt_ff;

   // item
   mbp_pkg::cmd_type cmd_ff;
   logic [31:0] quo_ff;
   logic [8:0]  rem_ff;
   logic [8:0]  dvs_ff;

   // scan results
   logic            hit_found_ff, free_found_ff, vic_found_ff;
   logic [IW-1:0]   hit_slot_ff, free_slot_ff, vic_slot_ff;
   logic [IW-1:0]   hit_rank_ff, vic_rank_ff;
   logic [TAG_BITS-1:0] vic_tag_ff;
   logic            vic_dirty_ff;
   logic [CW-1:0]   used_ff;

   // decision
   mbp_pkg::status_type status_ff;
   logic [IW-1:0]   tgt_ff;
   logic            pall_ff, pbelow_ff;
   logic [IW-1:0]   plim_ff;
   logic [19:0]     off_ff;
   logic [31:0]     evict_out_ff;
   logic            wb_out_ff;
   logic [31:0]     acc_ff, hits_ff;

   mbp_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;

   // divider step
   logic [9:0] div_r;
   logic       div_ge;
   assign div_r  = {rem_ff, quo_ff[31]};
   assign div_ge = div_r >= {1'b0, dvs_ff};

   logic [TAG_BITS-1:0] tag_cur;
   assign tag_cur = TAG_BITS'(quo_ff);

   logic [IW-1:0] idx;
   assign idx = IW'(cnt_ff - CW'(1));

   logic [CW-1:0] lim;
   always_comb begin
      if (fiu_ff == 5'd0) lim = CW'(1);
      else if (32'(fiu_ff) > FRAMES) lim = CW'(FRAMES);
      else lim = CW'(fiu_ff);
   end

   logic [21:0] prod;
   assign prod = 22'(rem_ff) * 22'(sbytes_ff);

   logic cnt_last;
   assign cnt_last = (cnt_ff == CW'(FRAMES));

   assign req_stall = (state_ff != mbp_pkg::FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rd_addr   = cnt_last ? '0 : IW'(cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbp_pkg::FSM_IDLE: if (req_valid) state_in = mbp_pkg::FSM_DIV;
         mbp_pkg::FSM_DIV:  if (dcnt_ff == 6'd31) state_in = mbp_pkg::FSM_SCAN;
         mbp_pkg::FSM_SCAN: if (cnt_last) state_in = mbp_pkg::FSM_DEC;
         mbp_pkg::FSM_DEC: begin
            if (cmd_ff == mbp_pkg::CMD_PIN || cmd_ff == mbp_pkg::CMD_UNPIN)
               state_in = hit_found_ff ? mbp_pkg::FSM_UPD : mbp_pkg::FSM_OUT;
            else if (!hit_found_ff && used_ff >= lim && !vic_found_ff)
               state_in = mbp_pkg::FSM_OUT;
            else
               state_in = mbp_pkg::FSM_UPD;
         end
         mbp_pkg::FSM_UPD:  if (cnt_last) state_in = mbp_pkg::FSM_OUT;
         mbp_pkg::FSM_OUT:  if (!rsp_valid_ff || !rsp_stall) state_in = mbp_pkg::FSM_IDLE;
         default:           state_in = mbp_pkg::FSM_IDLE;
      endcase
   end

   // update-pass write data: target entry rewritten, others maybe promoted
   always_comb begin
      wr_en   = (state_ff == mbp_pkg::FSM_UPD) && (cnt_ff != '0);
      wr_addr = idx;
      wr_data = rd_ff;
      if (idx == tgt_ff) begin
         case (status_ff)
            mbp_pkg::ST_PIN_DONE: begin
               if (cmd_ff == mbp_pkg::CMD_PIN) begin
                  if (rd_ff.pins != 8'hFF) wr_data.pins = rd_ff.pins + 8'd1;
               end else if (rd_ff.pins != 8'd0) begin
                  wr_data.pins = rd_ff.pins - 8'd1;
               end
            end
            mbp_pkg::ST_HIT: begin
               wr_data.rank = '0;
               if (cmd_ff == mbp_pkg::CMD_WRITE) wr_data.dirty = 1'b1;
            end
            default: begin      // fill, free or after eviction
               wr_data.tag   = tag_cur;
               wr_data.dirty = (cmd_ff == mbp_pkg::CMD_WRITE);
               wr_data.pins  = 8'd0;
               wr_data.rank  = '0;
            end
         endcase
      end else if (valid_ff[idx] && (pall_ff || (pbelow_ff && rd_ff.rank < plim_ff))) begin
         wr_data.rank = rd_ff.rank + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbp_pkg::FSM_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         hits_ff      <= '0;
         spb_ff       <= 9'd4;
         sbytes_ff    <= 13'd512;
         fiu_ff       <= 5'd16;
         cnt_ff       <= '0;
         dcnt_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               mbp_pkg::CSR_SECTORS_PER_BLOCK: spb_ff    <= csr_wdata[8:0];
               mbp_pkg::CSR_SECTOR_BYTES:      sbytes_ff <= csr_wdata[12:0];
               mbp_pkg::CSR_FRAMES_IN_USE:     fiu_ff    <= csr_wdata[4:0];
               default: ;
            endcase
         end
         // output state reloads the result register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != mbp_pkg::FSM_OUT)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            mbp_pkg::FSM_IDLE: begin
               cnt_ff  <= '0;
               dcnt_ff <= '0;
               if (req_valid) begin
                  cmd_ff        <= req_data.cmd;
                  quo_ff        <= req_data.sector_num;
                  rem_ff        <= '0;
                  dvs_ff        <= (spb_ff == 9'd0) ? 9'd1 : spb_ff;
                  hit_found_ff  <= 1'b0;
                  free_found_ff <= 1'b0;
                  vic_found_ff  <= 1'b0;
                  used_ff       <= '0;
               end
            end
            mbp_pkg::FSM_DIV: begin
               dcnt_ff <= dcnt_ff + 6'd1;
               quo_ff  <= {quo_ff[30:0], div_ge};
               rem_ff  <= div_ge ? 9'(div_r - {1'b0, dvs_ff}) : div_r[8:0];
            end
            mbp_pkg::FSM_SCAN: begin
               cnt_ff <= cnt_last ? '0 : cnt_ff + CW'(1);
               if (cnt_ff != '0) begin
                  if (valid_ff[idx]) begin
                     used_ff <= used_ff + CW'(1);
                     if (!hit_found_ff && rd_ff.tag == tag_cur) begin
                        hit_found_ff <= 1'b1;
                        hit_slot_ff  <= idx;
                        hit_rank_ff  <= rd_ff.rank;
                     end
                     if (rd_ff.pins == 8'd0 && (!vic_found_ff || rd_ff.rank < vic_rank_ff)) begin
                        vic_found_ff <= 1'b1;
                        vic_slot_ff  <= idx;
                        vic_rank_ff  <= rd_ff.rank;
                        vic_tag_ff   <= rd_ff.tag;
                        vic_dirty_ff <= rd_ff.dirty;
                     end
                  end else if (!free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_slot_ff  <= idx;
                  end
               end
            end
            mbp_pkg::FSM_DEC: begin
               pall_ff      <= 1'b0;
               pbelow_ff    <= 1'b0;
               plim_ff      <= '0;
               evict_out_ff <= '0;
               wb_out_ff    <= 1'b0;
               off_ff       <= (prod > 22'hFFFFF) ? 20'hFFFFF : prod[19:0];
               tgt_ff       <= hit_slot_ff;
               if (cmd_ff == mbp_pkg::CMD_PIN || cmd_ff == mbp_pkg::CMD_UNPIN) begin
                  status_ff <= hit_found_ff ? mbp_pkg::ST_PIN_DONE : mbp_pkg::ST_NOT_RESIDENT;
               end else begin
                  if (acc_ff != 32'hFFFF_FFFF) acc_ff <= acc_ff + 32'd1;
                  if (hit_found_ff) begin
                     if (hits_ff != 32'hFFFF_FFFF) hits_ff <= hits_ff + 32'd1;
                     status_ff <= mbp_pkg::ST_HIT;
                     pbelow_ff <= 1'b1;
                     plim_ff   <= hit_rank_ff;
                  end else if (used_ff < lim) begin
                     status_ff         <= mbp_pkg::ST_FILL_FREE;
                     tgt_ff            <= free_slot_ff;
                     pall_ff           <= 1'b1;
                     valid_ff[free_slot_ff] <= 1'b1;
                  end else if (vic_found_ff) begin
                     status_ff    <= mbp_pkg::ST_FILL_EVICT;
                     tgt_ff       <= vic_slot_ff;
                     pbelow_ff    <= 1'b1;
                     plim_ff      <= vic_rank_ff;
                     evict_out_ff <= 32'(vic_tag_ff);
                     wb_out_ff    <= vic_dirty_ff;
                  end else begin
                     status_ff <= mbp_pkg::ST_ALL_PINNED;
                  end
               end
            end
            mbp_pkg::FSM_UPD: begin
               cnt_ff <= cnt_last ? '0 : cnt_ff + CW'(1);
            end
            mbp_pkg::FSM_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_ff.status            <= status_ff;
                  rsp_ff.frame_slot        <= 4'd0;
                  rsp_ff.byte_offset       <= 20'd0;
                  rsp_ff.fill_block        <= 32'd0;
                  rsp_ff.evicted_block     <= evict_out_ff;
                  rsp_ff.writeback_needed  <= wb_out_ff;
                  rsp_ff.total_accesses    <= acc_ff;
                  rsp_ff.hit_count         <= hits_ff;
                  if (status_ff == mbp_pkg::ST_HIT || status_ff == mbp_pkg::ST_FILL_FREE ||
                      status_ff == mbp_pkg::ST_FILL_EVICT || status_ff == mbp_pkg::ST_PIN_DONE)
                     rsp_ff.frame_slot <= 4'(tgt_ff);
                  if (status_ff == mbp_pkg::ST_HIT || status_ff == mbp_pkg::ST_FILL_FREE ||
                      status_ff == mbp_pkg::ST_FILL_EVICT)
                     rsp_ff.byte_offset <= off_ff;
                  if (status_ff == mbp_pkg::ST_FILL_FREE || status_ff == mbp_pkg::ST_FILL_EVICT)
                     rsp_ff.fill_block <= quo_ff;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
